// File: rtl/pps_pkg.sv
// Shared constants, codes and types for the pulsed pump swim sequencer.
package pps_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned MS_W   = 16;
	localparam int unsigned LVL_W  = 8;
	localparam int unsigned ANG_W  = 12;
	localparam int unsigned TOL_W  = 11;
	localparam int unsigned CFG_W  = 16;

	// pulse cycle stages
	localparam logic [1:0] STAGE_IDLE  = 2'd0;
	localparam logic [1:0] STAGE_POWER = 2'd1;
	localparam logic [1:0] STAGE_REST  = 2'd2;

	// command codes
	localparam logic [2:0] FN_REST     = 3'd0;
	localparam logic [2:0] FN_SWIM     = 3'd1;
	localparam logic [2:0] FN_LEFT     = 3'd2;
	localparam logic [2:0] FN_RIGHT    = 3'd3;
	localparam logic [2:0] FN_LEFT_TO  = 3'd4;
	localparam logic [2:0] FN_RIGHT_TO = 3'd5;
	localparam logic [2:0] FN_FLIP     = 3'd6;
	localparam logic [2:0] FN_STAB     = 3'd7;

	// configuration register indexes
	localparam logic [1:0] CFG_POWER = 2'd0;
	localparam logic [1:0] CFG_REST  = 2'd1;
	localparam logic [1:0] CFG_TOL   = 2'd2;

	localparam logic [LVL_W-1:0] TURN_LEVEL  = 8'd75;
	localparam logic [MS_W-1:0]  POWER_RESET = 16'd500;
	localparam logic [MS_W-1:0]  REST_RESET  = 16'd500;
	localparam logic [TOL_W-1:0] TOL_RESET   = 11'd100;

	typedef struct packed {
		logic [1:0]        stage;
		logic [TIME_W-1:0] start_time;
		logic [LVL_W-1:0]  red_level;
		logic [LVL_W-1:0]  blue_level;
	} pulse_state_t;

	typedef struct packed {
		logic [MS_W-1:0]  power_time_ms;
		logic [MS_W-1:0]  rest_time_ms;
		logic [TOL_W-1:0] turn_tolerance;
	} pulse_cfg_t;

	typedef struct packed {
		logic [LVL_W-1:0] red_power;
		logic [LVL_W-1:0] blue_power;
		logic [1:0]       stage_now;
	} pulse_result_t;

endpackage

// File: rtl/pulsed_pump_swim_sequencer.sv
// Pulsed two-pump swim sequencer: top level with config, state and output buffer.
// A result is registered into the output register, or into the skid register while the output is stalled.
// Throughput: one command per cycle while in_stall is low; the state update finishes in the accepting cycle.
// A two-entry output buffer (output register plus skid register) keeps input flowing
// while a result is stalled until the skid register fills; in_stall rises only when both are full.
// Reset: stage idle, start time and levels zero, power/rest 500 ms, tolerance 100.
module pulsed_pump_swim_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [pps_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        func,
	input  logic [pps_pkg::TIME_W-1:0]        now_ms,
	input  logic [pps_pkg::LVL_W-1:0]         red_request,
	input  logic [pps_pkg::LVL_W-1:0]         blue_request,
	input  logic signed [pps_pkg::ANG_W-1:0]  target_angle,
	input  logic signed [pps_pkg::ANG_W-1:0]  yaw_angle,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pps_pkg::LVL_W-1:0]         red_power,
	output logic [pps_pkg::LVL_W-1:0]         blue_power,
	output logic [1:0]                        stage_now
);
	import pps_pkg::*;

	pulse_cfg_t    cfg_q;
	pulse_state_t  st_q;
	pulse_state_t  st_nxt;
	pulse_result_t res;
	pulse_result_t out_q;
	pulse_result_t skid_q;
	logic          out_valid_q;
	logic          skid_valid_q;
	logic          in_xfer;
	logic          out_free;

	assign in_stall = skid_valid_q;
	assign in_xfer  = in_valid && !skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_time_ms  <= POWER_RESET;
			cfg_q.rest_time_ms   <= REST_RESET;
			cfg_q.turn_tolerance <= TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POWER: cfg_q.power_time_ms  <= cfg_data;
				CFG_REST:  cfg_q.rest_time_ms   <= cfg_data;
				CFG_TOL:   cfg_q.turn_tolerance <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	pps_step u_step (
		.cfg          (cfg_q),
		.cur          (st_q),
		.func         (func),
		.now_ms       (now_ms),
		.red_request  (red_request),
		.blue_request (blue_request),
		.target_angle (target_angle),
		.yaw_angle    (yaw_angle),
		.nxt          (st_nxt)
	);

	assign res.red_power  = st_nxt.red_level;
	assign res.blue_power = st_nxt.blue_level;
	assign res.stage_now  = st_nxt.stage;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_xfer) begin
			st_q <= st_nxt;
		end
	end

	// output register and skid register valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (in_xfer)
				out_q <= res;
		end else if (in_xfer) begin
			skid_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign red_power  = out_q.red_power;
	assign blue_power = out_q.blue_power;
	assign stage_now  = out_q.stage_now;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_no_stage3: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.stage != 2'd3)
		else $error("pulse stage reached an unused code");

	a_rest_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && func == FN_REST |=>
		st_q.stage == STAGE_IDLE && st_q.red_level == '0 && st_q.blue_level == '0)
		else $error("rest command did not clear stage and levels");

	a_idle_latches: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && func == FN_SWIM && st_q.stage == STAGE_IDLE |=>
		st_q.stage == STAGE_POWER && st_q.start_time == $past(now_ms))
		else $error("idle swim step did not latch start time");

endmodule

// File: rtl/pps_step.sv
// Next-state logic of the pulse cycle for one command.
module pps_step (
	input  pps_pkg::pulse_cfg_t               cfg,
	input  pps_pkg::pulse_state_t             cur,
	input  logic [2:0]                        func,
	input  logic [pps_pkg::TIME_W-1:0]        now_ms,
	input  logic [pps_pkg::LVL_W-1:0]         red_request,
	input  logic [pps_pkg::LVL_W-1:0]         blue_request,
	input  logic signed [pps_pkg::ANG_W-1:0]  target_angle,
	input  logic signed [pps_pkg::ANG_W-1:0]  yaw_angle,
	output pps_pkg::pulse_state_t             nxt
);
	import pps_pkg::*;

	logic [TIME_W-1:0]      elapsed;
	logic [MS_W:0]          total;
	logic signed [ANG_W+1:0] tgt_x;
	logic signed [ANG_W+1:0] yaw_x;
	logic signed [ANG_W+1:0] tol_x;
	logic signed [ANG_W+1:0] band_hi;
	logic signed [ANG_W+1:0] band_lo;
	logic                   outside;
	logic                   yaw_neg;
	logic                   step_en;
	logic [LVL_W-1:0]       lvl_red;
	logic [LVL_W-1:0]       lvl_blue;

	assign elapsed = now_ms - cur.start_time;
	assign total   = {1'b0, cfg.power_time_ms} + {1'b0, cfg.rest_time_ms};
	assign tgt_x   = {{2{target_angle[ANG_W-1]}}, target_angle};
	assign yaw_x   = {{2{yaw_angle[ANG_W-1]}}, yaw_angle};
	assign tol_x   = $signed({3'b000, cfg.turn_tolerance});
	assign band_hi = tgt_x + tol_x;
	assign band_lo = tgt_x - tol_x;
	assign outside = !((yaw_x <= band_hi) && (yaw_x >= band_lo));
	assign yaw_neg = yaw_angle[ANG_W-1];

	// pick the levels and whether the cycle steps at all
	always_comb begin
		step_en  = 1'b1;
		lvl_red  = TURN_LEVEL;
		lvl_blue = '0;
		unique case (func)
			FN_REST: step_en = 1'b0;
			FN_SWIM: begin
				lvl_red  = red_request;
				lvl_blue = blue_request;
			end
			FN_LEFT: ;
			FN_RIGHT: begin
				lvl_red  = '0;
				lvl_blue = TURN_LEVEL;
			end
			FN_LEFT_TO: step_en = outside;
			FN_RIGHT_TO: begin
				step_en  = outside;
				lvl_red  = '0;
				lvl_blue = TURN_LEVEL;
			end
			FN_FLIP: begin
				if (!yaw_neg) begin
					lvl_red  = '0;
					lvl_blue = TURN_LEVEL;
				end
			end
			default: begin
				if (yaw_neg) begin
					lvl_red  = '0;
					lvl_blue = TURN_LEVEL;
				end
			end
		endcase
	end

	always_comb begin
		nxt = cur;
		if (func == FN_REST) begin
			nxt.stage      = STAGE_IDLE;
			nxt.red_level  = '0;
			nxt.blue_level = '0;
		end else if (step_en) begin
			unique case (cur.stage)
				STAGE_IDLE: begin
					nxt.start_time = now_ms;
					nxt.stage      = STAGE_POWER;
				end
				STAGE_POWER: begin
					nxt.red_level  = lvl_red;
					nxt.blue_level = lvl_blue;
					if (elapsed > {{(TIME_W-MS_W){1'b0}}, cfg.power_time_ms})
						nxt.stage = STAGE_REST;
				end
				STAGE_REST: begin
					nxt.red_level  = '0;
					nxt.blue_level = '0;
					if (elapsed > {{(TIME_W-MS_W-1){1'b0}}, total})
						nxt.stage = STAGE_IDLE;
				end
				default: ;
			endcase
		end
	end

endmodule

// File: dv/pulsed_pump_swim_sequencer_tb.sv
// Self-checking testbench for the pulsed pump swim sequencer: directed and random commands.
`timescale 1ns / 100ps

module pulsed_pump_swim_sequencer_tb;
	import pps_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;

	// Tracks the pulse cycle and the pump levels, queues the levels each command should give
	class pump_pulse_tracker;
		logic [MS_W-1:0]   power_ms;
		logic [MS_W-1:0]   rest_ms;
		logic [TOL_W-1:0]  tol;
		logic [1:0]        stage;
		logic [TIME_W-1:0] start_ms;
		logic [LVL_W-1:0]  red;
		logic [LVL_W-1:0]  blue;
		pulse_result_t     pending_q[$];
		int                errors;

		function new();
			power_ms = POWER_RESET;
			rest_ms  = REST_RESET;
			tol      = TOL_RESET;
			stage    = STAGE_IDLE;
			start_ms = '0;
			red      = '0;
			blue     = '0;
			errors   = 0;
		endfunction

		function void note_write(logic [1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_POWER: power_ms = data;
				CFG_REST:  rest_ms = data;
				CFG_TOL:   tol = data[TOL_W-1:0];
				default: ;
			endcase
		endfunction

		function void advance(logic [TIME_W-1:0] now, logic [LVL_W-1:0] r, logic [LVL_W-1:0] b);
			logic [TIME_W-1:0] elapsed;
			logic [MS_W:0]     total;
			elapsed = now - start_ms;
			total = {1'b0, power_ms} + {1'b0, rest_ms};
			case (stage)
				STAGE_IDLE: begin
					start_ms = now;
					stage = STAGE_POWER;
				end
				STAGE_POWER: begin
					red = r;
					blue = b;
					if (elapsed > power_ms)
						stage = STAGE_REST;
				end
				STAGE_REST: begin
					red = '0;
					blue = '0;
					if (elapsed > total)
						stage = STAGE_IDLE;
				end
				default: ;
			endcase
		endfunction

		function bit off_target(logic signed [ANG_W-1:0] target, logic signed [ANG_W-1:0] yaw);
			int t, y, w;
			t = int'(target);
			y = int'(yaw);
			w = int'(tol);
			return !(y <= t + w && y >= t - w);
		endfunction

		function void note_command(logic [2:0] fn, logic [TIME_W-1:0] now,
				logic [LVL_W-1:0] rreq, logic [LVL_W-1:0] breq,
				logic signed [ANG_W-1:0] target, logic signed [ANG_W-1:0] yaw);
			pulse_result_t res;
			case (fn)
				FN_REST: begin
					stage = STAGE_IDLE;
					red = '0;
					blue = '0;
				end
				FN_SWIM:     advance(now, rreq, breq);
				FN_LEFT:     advance(now, TURN_LEVEL, '0);
				FN_RIGHT:    advance(now, '0, TURN_LEVEL);
				FN_LEFT_TO:  if (off_target(target, yaw)) advance(now, TURN_LEVEL, '0);
				FN_RIGHT_TO: if (off_target(target, yaw)) advance(now, '0, TURN_LEVEL);
				FN_FLIP: begin
					if (yaw < 0)
						advance(now, TURN_LEVEL, '0);
					else
						advance(now, '0, TURN_LEVEL);
				end
				default: begin
					if (yaw < 0)
						advance(now, '0, TURN_LEVEL);
					else
						advance(now, TURN_LEVEL, '0);
				end
			endcase
			res.red_power = red;
			res.blue_power = blue;
			res.stage_now = stage;
			pending_q.push_back(res);
		endfunction

		function void compare_field(string label, int want, int got);
			if (want != got) begin
				$display("%0t %s mismatch: expected %0d actual %0d", $time, label, want, got);
				errors++;
			end
		endfunction

		function void check_levels(logic [LVL_W-1:0] r, logic [LVL_W-1:0] b, logic [1:0] s);
			pulse_result_t want;
			if (pending_q.size() == 0) begin
				$display("%0t unexpected result: expected none actual red %0d blue %0d stage %0d",
					$time, r, b, s);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			compare_field("red_power", int'(want.red_power), int'(r));
			compare_field("blue_power", int'(want.blue_power), int'(b));
			compare_field("stage_now", int'(want.stage_now), int'(s));
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [1:0]               cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [2:0]               func = FN_REST;
	logic [TIME_W-1:0]        now_ms = '0;
	logic [LVL_W-1:0]         red_request = '0;
	logic [LVL_W-1:0]         blue_request = '0;
	logic signed [ANG_W-1:0]  target_angle = '0;
	logic signed [ANG_W-1:0]  yaw_angle = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [LVL_W-1:0]         red_power;
	logic [LVL_W-1:0]         blue_power;
	logic [1:0]               stage_now;

	pump_pulse_tracker tracker = new();
	bit                steady = 1'b0;
	logic [TIME_W-1:0] clock_ms = 32'hFFFF_F000;

	pulsed_pump_swim_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .now_ms(now_ms), .red_request(red_request), .blue_request(blue_request),
		.target_angle(target_angle), .yaw_angle(yaw_angle),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_power(red_power), .blue_power(blue_power), .stage_now(stage_now)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				tracker.note_write(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				tracker.note_command(func, now_ms, red_request, blue_request,
					target_angle, yaw_angle);
			if (out_valid && !out_stall)
				tracker.check_levels(red_power, blue_power, stage_now);
		end
	end

	// mostly short stalls, the odd long one, and long free-running stretches
	initial begin
		int r;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else if (r < 85) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else if (r < 95) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(100, 200)) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_command(logic [2:0] fn, logic [TIME_W-1:0] now,
			logic [LVL_W-1:0] rreq, logic [LVL_W-1:0] breq,
			logic signed [ANG_W-1:0] target, logic signed [ANG_W-1:0] yaw);
		int gap;
		func <= fn;
		now_ms <= now;
		red_request <= rreq;
		blue_request <= breq;
		target_angle <= target;
		yaw_angle <= yaw;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and let every outstanding result arrive
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_regs(logic [CFG_W-1:0] power, logic [CFG_W-1:0] rest,
			logic [CFG_W-1:0] tol_data);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_SPARE;
		cfg_data <= CFG_W'($urandom);
		@(posedge clk);
		cfg_index <= CFG_POWER;
		cfg_data <= power;
		@(posedge clk);
		cfg_index <= CFG_REST;
		cfg_data <= rest;
		@(posedge clk);
		cfg_index <= CFG_TOL;
		cfg_data <= tol_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(int count);
		int step_max, r, t, y, w;
		logic [2:0] fn;
		logic [TIME_W-1:0] now;
		logic signed [ANG_W-1:0] target, yaw;
		steady = ($urandom_range(0, 3) == 0);
		// scale the time steps so each stage lasts a handful of commands
		step_max = (int'(tracker.power_ms) + int'(tracker.rest_ms)) / 6 + 2;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				now = $urandom;
				clock_ms = now;
			end else if (r < 6) begin
				now = clock_ms - $urandom_range(0, step_max);
			end else begin
				clock_ms = clock_ms + $urandom_range(0, step_max);
				now = clock_ms;
			end
			r = $urandom_range(0, 99);
			if (r < 5)
				fn = FN_REST;
			else if (r < 50)
				fn = FN_SWIM;
			else
				fn = 3'($urandom_range(FN_LEFT, FN_STAB));
			if ($urandom_range(0, 4) == 0) begin
				target = ANG_W'($urandom);
				yaw = ANG_W'($urandom);
			end else begin
				w = int'(tracker.tol);
				t = $urandom_range(0, 3600) - 1800;
				y = t + $urandom_range(0, 2 * w + 60) - w - 30;
				target = t[ANG_W-1:0];
				yaw = y[ANG_W-1:0];
			end
			send_command(fn, now, LVL_W'($urandom), LVL_W'($urandom), target, yaw);
		end
	endtask

	initial begin
		int sel;
		logic [CFG_W-1:0] power, rest, tol_data;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 500 ms powered, 500 ms rest, band of 10 degrees
		send_command(FN_SWIM, 32'd0, 8'd255, 8'd255, 12'sd0, 12'sd0);
		send_command(FN_SWIM, 32'd100, 8'd255, 8'd0, 12'sd0, 12'sd0);
		send_command(FN_SWIM, 32'd500, 8'd0, 8'd255, 12'sd0, 12'sd0);
		send_command(FN_SWIM, 32'd501, 8'd255, 8'd255, 12'sd0, 12'sd0);
		send_command(FN_LEFT, 32'd1000, 8'd0, 8'd0, 12'sd0, 12'sd0);
		send_command(FN_RIGHT, 32'd1001, 8'd0, 8'd0, 12'sd0, 12'sd0);
		// elapsed time across the 32-bit wrap
		send_command(FN_LEFT, 32'hFFFF_FF00, 8'd0, 8'd0, 12'sd0, 12'sd0);
		send_command(FN_LEFT, 32'h0000_0010, 8'd0, 8'd0, 12'sd0, 12'sd0);
		send_command(FN_RIGHT, 32'h0000_0200, 8'd0, 8'd0, 12'sd0, 12'sd0);
		send_command(FN_REST, 32'h0000_0300, 8'd255, 8'd255, 12'sd0, 12'sd0);
		// band edges: inside leaves everything alone, outside steps the cycle; then flip, stab and swim
		send_command(FN_LEFT_TO, 32'd4000, 8'd0, 8'd0, 12'sd0, 12'sd100);
		send_command(FN_RIGHT_TO, 32'd4100, 8'd0, 8'd0, 12'sd0, -12'sd100);
		send_command(FN_LEFT_TO, 32'd5000, 8'd0, 8'd0, 12'sd0, 12'sd101);
		send_command(FN_RIGHT_TO, 32'd5100, 8'd0, 8'd0, -12'sd1800, -12'sd1901);
		send_command(FN_RIGHT_TO, 32'd5150, 8'd0, 8'd0, 12'sd1800, 12'sd1700);
		send_command(FN_LEFT_TO, 32'd5200, 8'd0, 8'd0, 12'h7FF, 12'h800);
		send_command(FN_FLIP, 32'd5300, 8'd0, 8'd0, 12'sd0, -12'sd1);
		send_command(FN_FLIP, 32'd5400, 8'd0, 8'd0, 12'sd0, 12'sd0);
		send_command(FN_STAB, 32'd5501, 8'd0, 8'd0, 12'sd0, 12'h800);
		send_command(FN_STAB, 32'd6501, 8'd0, 8'd0, 12'sd0, 12'h7FF);
		send_command(FN_SWIM, 32'hFFFF_FFFF, 8'hAA, 8'h55, 12'h555, 12'hAAA);
		send_command(FN_SWIM, 32'd0, 8'h55, 8'hAA, 12'hAAA, 12'h555);

		program_regs(16'd0, 16'd0, 16'd0);
		run_phase(135);
		// upper bits of the tolerance write must be dropped
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(135);
		for (int ph = 0; ph < 7; ph++) begin
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				power = CFG_W'($urandom_range(0, 40));
				rest = CFG_W'($urandom_range(0, 40));
			end else if (sel < 9) begin
				power = CFG_W'($urandom_range(0, 2000));
				rest = CFG_W'($urandom_range(0, 2000));
			end else begin
				power = CFG_W'($urandom);
				rest = CFG_W'($urandom);
			end
			if ($urandom_range(0, 9) == 0)
				tol_data = CFG_W'($urandom);
			else
				tol_data = CFG_W'($urandom_range(0, 1800));
			program_regs(power, rest, tol_data);
			run_phase(135);
		end

		settle();
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
